// ===== sv/u8l1_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the UTF-8 to Latin-1 escaping decoder.
package u8l1_pkg;

    localparam int unsigned SEQ_DEPTH   = 6;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Kinds of output job handed from the front to the back
    localparam logic [1:0] K_PLAIN = 2'd0;  // one raw byte
    localparam logic [1:0] K_ESC   = 2'd1;  // backslash and one letter
    localparam logic [1:0] K_HEX   = 2'd2;  // one to six \xNN escapes

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;

    typedef struct packed {
        logic [1:0]                     kind;
        logic [2:0]                     nhex;
        logic [SEQ_DEPTH-1:0][7:0]      data;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            hex_char = 8'h30 + {4'd0, nib};
        end else begin
            hex_char = 8'h57 + {4'd0, nib};
        end
    endfunction

endpackage

// ===== sv/u8l1_front.sv =====
`timescale 1ns / 1ps
// Front end: decodes UTF-8 input items and queues at most one output job per item.
module u8l1_front
    import u8l1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0]  r_delim;
    logic [2:0]  r_need, n_need;
    logic [2:0]  r_cnt, n_cnt;
    logic [30:0] r_acc, n_acc;
    logic        r_resync, n_resync;
    logic [7:0]  r_seq [SEQ_DEPTH];

    logic        seq_we;
    logic [2:0]  seq_idx;
    logic        has_job;
    logic        is_cont;
    logic        is_ff;
    logic        esc_ascii;
    t_job        job;

    assign is_cont = (i_byte[7:6] == 2'b10);
    assign is_ff   = (i_byte[7:1] == 7'h7F);
    assign esc_ascii = (i_byte < 8'h20) || (i_byte == 8'h7F) || (i_byte == r_delim)
                     || ((r_delim != 8'd0) && (i_byte == CH_BSLASH));

    always_comb begin
        n_need   = r_need;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_resync = r_resync;
        seq_we   = 1'b0;
        seq_idx  = r_cnt;
        has_job  = 1'b0;
        job.kind = K_HEX;
        job.nhex = 3'd1;
        for (int k = 0; k < SEQ_DEPTH; k++) begin
            job.data[k] = i_byte;
        end

        if (r_resync && (is_cont || is_ff)) begin
            has_job = 1'b1;
        end else begin
            n_resync = 1'b0;
            if (r_need == 3'd0) begin
                if (!i_byte[7]) begin
                    has_job = 1'b1;
                    if (!esc_ascii) begin
                        job.kind = K_PLAIN;
                    end else begin
                        job.kind = K_ESC;
                        case (i_byte)
                            8'h0A:   job.data[0] = 8'h6E;
                            8'h0D:   job.data[0] = 8'h72;
                            8'h0C:   job.data[0] = 8'h66;
                            8'h0B:   job.data[0] = 8'h76;
                            8'h08:   job.data[0] = 8'h62;
                            8'h00:   job.data[0] = 8'h30;
                            default: job.kind    = K_HEX;
                        endcase
                    end
                end else if (i_byte[7:5] == 3'b110) begin
                    n_acc = {26'd0, i_byte[4:0]};
                    n_need = 3'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_acc = {27'd0, i_byte[3:0]};
                    n_need = 3'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_acc = {28'd0, i_byte[2:0]};
                    n_need = 3'd3;
                end else if (i_byte[7:2] == 6'b111110) begin
                    n_acc = {29'd0, i_byte[1:0]};
                    n_need = 3'd4;
                end else if (i_byte[7:1] == 7'b1111110) begin
                    n_acc = {30'd0, i_byte[0]};
                    n_need = 3'd5;
                end else begin
                    // stray continuation or 0xFE/0xFF
                    has_job  = 1'b1;
                    n_resync = 1'b1;
                end
                if (i_byte[7:6] == 2'b11 && !is_ff) begin
                    seq_we  = 1'b1;
                    seq_idx = 3'd0;
                    n_cnt   = 3'd1;
                end
            end else begin
                // stored bytes first, this byte at the end
                for (int k = 0; k < SEQ_DEPTH; k++) begin
                    job.data[k] = (3'(k) == r_cnt) ? i_byte : r_seq[k];
                end
                job.nhex = r_cnt + 3'd1;
                if (!is_cont) begin
                    has_job  = 1'b1;
                    n_need   = 3'd0;
                    n_cnt    = 3'd0;
                    n_resync = 1'b1;
                end else begin
                    seq_we = 1'b1;
                    n_cnt  = r_cnt + 3'd1;
                    n_acc  = {r_acc[24:0], i_byte[5:0]};
                    n_need = r_need - 3'd1;
                    if (n_need == 3'd0) begin
                        has_job = 1'b1;
                        n_cnt   = 3'd0;
                        if (n_acc[30:8] == 23'd0 && n_acc[7]) begin
                            job.kind    = K_PLAIN;
                            job.data[0] = n_acc[7:0];
                        end
                    end
                end
            end
        end

        // end of string: drop anything pending
        if (i_end) begin
            n_need   = 3'd0;
            n_cnt    = 3'd0;
            n_acc    = 31'd0;
            n_resync = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim  <= 8'd0;
            r_need   <= 3'd0;
            r_cnt    <= 3'd0;
            r_acc    <= 31'd0;
            r_resync <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_need   <= n_need;
                r_cnt    <= n_cnt;
                r_acc    <= n_acc;
                r_resync <= n_resync;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && seq_we) begin
            r_seq[seq_idx] <= i_byte;
        end
    end

    assign o_push = i_accept && has_job;
    assign o_job  = job;

endmodule

// ===== sv/u8l1_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the decoding front and the output back end.
module u8l1_queue
    import u8l1_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== sv/u8l1_back.sv =====
`timescale 1ns / 1ps
// Back end: expands queued jobs into output items through an output register.
module u8l1_back
    import u8l1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic [2:0] r_idx;
    logic [1:0] r_ph;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_olast;

    logic       step;
    logic       last;
    logic [7:0] cur;
    logic [7:0] nxt;

    assign step = !i_empty && (!r_ovalid || i_ready);
    assign cur  = i_head.data[r_idx];

    always_comb begin
        last = 1'b0;
        nxt  = i_head.data[0];
        case (i_head.kind)
            K_PLAIN: begin
                last = 1'b1;
            end
            K_ESC: begin
                last = (r_ph == 2'd1);
                nxt  = (r_ph == 2'd0) ? CH_BSLASH : i_head.data[0];
            end
            K_HEX: begin
                last = (r_ph == 2'd3) && (r_idx == i_head.nhex - 3'd1);
                case (r_ph)
                    2'd0:    nxt = CH_BSLASH;
                    2'd1:    nxt = CH_X;
                    2'd2:    nxt = hex_char(cur[7:4]);
                    default: nxt = hex_char(cur[3:0]);
                endcase
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 3'd0;
            r_ph     <= 2'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_ovalid <= 1'b1;
                if (last) begin
                    r_idx <= 3'd0;
                    r_ph  <= 2'd0;
                end else if (r_ph == 2'd3) begin
                    r_idx <= r_idx + 3'd1;
                    r_ph  <= 2'd0;
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_obyte <= nxt;
            r_olast <= last;
        end
    end

    assign o_pop   = step && last;
    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;

endmodule

// ===== sv/utf8_to_latin1_escaping_decoder_unit.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-8 to Latin-1 escaping decoder.
// Takes one UTF-8 byte per input item and writes a Latin-1 byte stream in
// which control bytes, the delimiter, the backslash (delimiter nonzero),
// invalid bytes and multi-byte code points outside 0x80..0xFF are escaped.
// The front end decodes an input item in the cycle it is accepted and queues
// at most one job; the back end turns each job into one to 24 output items,
// one per cycle while the output is ready, through an output register.
// Throughput is one input item per cycle while each item gives at most one
// output and the output is ready; longer jobs hold the back end, and input
// stalls once the job queue (QUEUE_DEPTH entries) is full. tlast on the
// output marks the last item produced by one input item; inputs that finish
// nothing produce no output. The user must write the delimiter register only
// while the block is idle; the block itself does not enforce it.
module utf8_to_latin1_escaping_decoder_unit
    import u8l1_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,   // delimiter
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,    // string_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast     // run_last
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job;
    t_job head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;

    u8l1_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_byte        (s_axis_tdata),
        .i_end         (s_axis_tlast),
        .o_push        (push),
        .o_job         (job)
    );

    u8l1_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    u8l1_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the UTF-8 to Latin-1 escaping decoder.
module tb_top
    import u8l1_pkg::*;
();

    localparam int WATCH_LIMIT = 2000;
    localparam int SETTLE_CYC  = 12;
    localparam int PHASE_ITEMS = 68;

    // Control bytes and escape letters of the decoder
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] LET_N   = 8'h6E;
    localparam logic [7:0] LET_R   = 8'h72;
    localparam logic [7:0] LET_F   = 8'h66;
    localparam logic [7:0] LET_V   = 8'h76;
    localparam logic [7:0] LET_B   = 8'h62;
    localparam logic [7:0] LET_0   = 8'h30;
    localparam int         TYPED_NONE = -1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_latin_item;

    typedef struct {
        logic [7:0]  b;
        logic        e;
        int          n;      // number of typed output bytes, or TYPED_NONE
        logic [31:0] w;      // typed bytes, first one in the top byte
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // string_end
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic       m_axis_tlast;           // run_last

    // Typed expectation travelling beside the current item
    int          tab_n = TYPED_NONE;
    logic [31:0] tab_w = 32'h0;

    utf8_to_latin1_escaping_decoder_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Decoder state as the testbench sees it
    logic [7:0]  delim_r;
    logic [2:0]  need_cnt;
    logic [2:0]  held_cnt;
    logic [30:0] cp_acc;
    logic [7:0]  held_bytes [SEQ_DEPTH];
    logic        in_resync;

    logic [7:0]  fresh_q [$];
    t_latin_item latin_q [$];
    int          mismatch_cnt = 0;
    int          in_cnt = 0;
    int          out_cnt = 0;
    int          dir_cnt = 0;
    int          phase_cnt = 0;
    bit          calm = 1'b0;

    function automatic logic [7:0] nib_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h61 + 8'(nib) - 8'd10);
    endfunction

    task automatic put_hex(input logic [7:0] b);
        fresh_q.push_back(CH_BSLASH);
        fresh_q.push_back(CH_X);
        fresh_q.push_back(nib_char(b[7:4]));
        fresh_q.push_back(nib_char(b[3:0]));
    endtask

    task automatic put_held();
        for (int k = 0; k < int'(held_cnt) && k < SEQ_DEPTH; k++) begin
            put_hex(held_bytes[k]);
        end
    endtask

    task automatic clear_decoder();
        need_cnt  = 3'd0;
        held_cnt  = 3'd0;
        cp_acc    = 31'd0;
        in_resync = 1'b0;
        for (int k = 0; k < SEQ_DEPTH; k++) held_bytes[k] = 8'h00;
    endtask

    task automatic open_seq(input logic [7:0] b, input logic [30:0] bits,
                            input logic [2:0] n);
        cp_acc        = bits;
        need_cnt      = n;
        held_bytes[0] = b;
        held_cnt      = 3'd1;
    endtask

    task automatic put_ascii(input logic [7:0] b);
        if (b < 8'h20 || b == CH_DEL || b == delim_r
            || (delim_r != 8'h00 && b == CH_BSLASH)) begin
            fresh_q.push_back(CH_BSLASH);
            case (b)
                CH_LF:   fresh_q.push_back(LET_N);
                CH_CR:   fresh_q.push_back(LET_R);
                CH_FF:   fresh_q.push_back(LET_F);
                CH_VT:   fresh_q.push_back(LET_V);
                CH_BS:   fresh_q.push_back(LET_B);
                CH_NUL:  fresh_q.push_back(LET_0);
                default: begin
                    fresh_q.push_back(CH_X);
                    fresh_q.push_back(nib_char(b[7:4]));
                    fresh_q.push_back(nib_char(b[3:0]));
                end
            endcase
        end else begin
            fresh_q.push_back(b);
        end
    endtask

    // Work out the output bytes of one input byte into fresh_q
    task automatic decode_utf8_byte(input logic [7:0] b, input logic e);
        bit done;
        done = 1'b0;
        fresh_q.delete();
        if (in_resync) begin
            if ((b >= 8'h80 && b < 8'hC0) || b >= 8'hFE) begin
                put_hex(b);
                done = 1'b1;
            end else begin
                in_resync = 1'b0;
            end
        end
        if (!done) begin
            if (need_cnt == 3'd0) begin
                if (b < 8'h80)                 put_ascii(b);
                else if (b[7:5] == 3'b110)     open_seq(b, 31'(b[4:0]), 3'd1);
                else if (b[7:4] == 4'b1110)    open_seq(b, 31'(b[3:0]), 3'd2);
                else if (b[7:3] == 5'b11110)   open_seq(b, 31'(b[2:0]), 3'd3);
                else if (b[7:2] == 6'b111110)  open_seq(b, 31'(b[1:0]), 3'd4);
                else if (b[7:1] == 7'b1111110) open_seq(b, 31'(b[0]), 3'd5);
                else begin
                    put_hex(b);
                    in_resync = 1'b1;
                end
            end else if (b < 8'h80 || b >= 8'hC0) begin
                put_held();
                put_hex(b);
                need_cnt  = 3'd0;
                held_cnt  = 3'd0;
                in_resync = 1'b1;
            end else begin
                if (held_cnt < 3'(SEQ_DEPTH)) begin
                    held_bytes[held_cnt] = b;
                    held_cnt = held_cnt + 3'd1;
                end
                cp_acc   = {cp_acc[24:0], b[5:0]};
                need_cnt = need_cnt - 3'd1;
                if (need_cnt == 3'd0) begin
                    if (cp_acc >= 31'h80 && cp_acc < 31'h100) fresh_q.push_back(cp_acc[7:0]);
                    else put_held();
                    held_cnt = 3'd0;
                end
            end
        end
        if (e) clear_decoder();
    endtask

    // Check the output side, then predict for the accepted input item
    always @(posedge i_clk) begin
        t_latin_item want;
        int          n;
        if (!i_rst_n) begin
            delim_r = 8'h00;
            clear_decoder();
        end else begin
            if (i_cfg_wr_en) delim_r = i_cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                out_cnt++;
                if (latin_q.size() == 0) begin
                    $error("unexpected output item: out_byte 0x%02h run_last %0b",
                           m_axis_tdata, m_axis_tlast);
                    mismatch_cnt++;
                end else begin
                    want = latin_q.pop_front();
                    if (m_axis_tdata !== want.data) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata);
                        mismatch_cnt++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("run_last: expected %0b, got %0b", want.last, m_axis_tlast);
                        mismatch_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_cnt++;
                decode_utf8_byte(s_axis_tdata, s_axis_tlast);
                if (tab_n != TYPED_NONE) begin
                    fresh_q.delete();
                    for (int k = 0; k < tab_n; k++) fresh_q.push_back(tab_w[31 - 8 * k -: 8]);
                end
                n = fresh_q.size();
                for (int k = 0; k < n; k++) begin
                    want.data = fresh_q[k];
                    want.last = (k == n - 1);
                    latin_q.push_back(want);
                end
            end
        end
    end

    // Random output back-pressure in bursts
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_cnt = $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stop a hung run
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || i_cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCH_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", quiet);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic e, input int n,
                             input logic [31:0] w);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= e;
        tab_n         <= n;
        tab_w         <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Drop valid and wait for every expected output, then let the block settle
    task automatic drain_out();
        s_axis_tvalid <= 1'b0;
        tab_n         <= TYPED_NONE;
        @(posedge i_clk);
        while (latin_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_delim(input logic [7:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        phase_cnt++;
    endtask

    function automatic t_dir_row row(input logic [7:0] b, input logic e, input int n,
                                     input logic [31:0] w);
        t_dir_row r;
        r.b = b;
        r.e = e;
        r.n = n;
        r.w = w;
        return r;
    endfunction

    // Append the n-byte encoding of cp, overlong where cp is small
    task automatic add_encoded(ref logic [7:0] q [$], input int unsigned cp, input int n);
        int unsigned lead;
        if (n == 1) begin
            q.push_back(8'(cp & 32'h7F));
        end else begin
            lead = ((32'hFF << (8 - n)) & 32'hFF)
                 | ((cp >> (6 * (n - 1))) & ((32'h1 << (7 - n)) - 1));
            q.push_back(8'(lead));
            for (int k = 1; k < n; k++) begin
                q.push_back(8'(32'h80 | ((cp >> (6 * (n - 1 - k))) & 32'h3F)));
            end
        end
    endtask

    task automatic add_chunk(ref logic [7:0] q [$]);
        int pick;
        int n;
        int m;
        pick = $urandom_range(0, 99);
        if (pick < 30)      add_encoded(q, $urandom_range(0, 8'h7F), 1);
        else if (pick < 45) add_encoded(q, $urandom_range(8'h80, 8'hFF), 2);
        else if (pick < 55) add_encoded(q, $urandom_range(32'h100, 32'h7FF), 2);
        else if (pick < 65) add_encoded(q, $urandom_range(32'h800, 32'hFFFF), 3);
        else if (pick < 72) add_encoded(q, $urandom_range(32'h10000, 32'h1FFFFF), 4);
        else if (pick < 76) add_encoded(q, $urandom_range(32'h200000, 32'h3FFFFFF), 5);
        else if (pick < 79) add_encoded(q, $urandom_range(32'h4000000, 32'h7FFFFFFF), 6);
        else if (pick < 84) add_encoded(q, $urandom_range(0, 8'hFF), $urandom_range(2, 6));
        else if (pick < 92) q.push_back(8'($urandom_range(0, 255)));
        else begin
            // truncated sequence closed by a byte that is no continuation
            n = $urandom_range(2, 6);
            m = $urandom_range(0, n - 2);
            q.push_back(8'(((32'hFF << (8 - n)) & 32'hFF)
                           | ($urandom & ((32'h1 << (7 - n)) - 1))));
            for (int k = 0; k < m; k++) q.push_back(8'(32'h80 | $urandom_range(0, 8'h3F)));
            q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                             : 8'($urandom_range(8'hC0, 8'hFF)));
        end
    endtask

    task automatic run_random(input int count);
        logic [7:0] chunk [$];
        int sent;
        sent = 0;
        while (sent < count) begin
            chunk.delete();
            add_chunk(chunk);
            foreach (chunk[k]) begin
                send_item(chunk[k], $urandom_range(0, 24) == 0, TYPED_NONE, 32'h0);
                sent++;
            end
        end
    endtask

    initial begin
        t_dir_row    dir_rows [$];
        logic [7:0]  delims [$];
        dir_rows.push_back(row(8'h41, 1'b0, 1, 32'h4100_0000));
        dir_rows.push_back(row(CH_LF, 1'b0, 2, 32'h5C6E_0000));
        dir_rows.push_back(row(CH_CR, 1'b0, 2, 32'h5C72_0000));
        dir_rows.push_back(row(CH_FF, 1'b0, 2, 32'h5C66_0000));
        dir_rows.push_back(row(CH_VT, 1'b0, 2, 32'h5C76_0000));
        dir_rows.push_back(row(CH_BS, 1'b0, 2, 32'h5C62_0000));
        dir_rows.push_back(row(CH_NUL, 1'b0, 2, 32'h5C30_0000));
        dir_rows.push_back(row(8'h01, 1'b0, 4, 32'h5C78_3031));
        dir_rows.push_back(row(CH_DEL, 1'b0, 4, 32'h5C78_3766));
        dir_rows.push_back(row(CH_BSLASH, 1'b0, 1, 32'h5C00_0000));
        // overlong two-byte form of 0x7F
        dir_rows.push_back(row(8'hC1, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'hBF, 1'b0, TYPED_NONE, 32'h0));
        // six-byte sequence, longest escape run
        dir_rows.push_back(row(8'hFC, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'h84, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'h80, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'h80, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'h80, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'h80, 1'b0, TYPED_NONE, 32'h0));
        // lone continuation, then resync
        dir_rows.push_back(row(8'h80, 1'b0, 4, 32'h5C78_3830));
        dir_rows.push_back(row(8'hFF, 1'b0, 4, 32'h5C78_6666));
        dir_rows.push_back(row(8'h41, 1'b0, 1, 32'h4100_0000));
        // broken sequence
        dir_rows.push_back(row(8'hE2, 1'b0, TYPED_NONE, 32'h0));
        dir_rows.push_back(row(8'h41, 1'b0, TYPED_NONE, 32'h0));
        // string end inside a sequence drops it silently
        dir_rows.push_back(row(8'hF0, 1'b0, 0, 32'h0));
        dir_rows.push_back(row(8'h90, 1'b1, 0, 32'h0));
        dir_rows.push_back(row(8'h80, 1'b0, 4, 32'h5C78_3830));

        delims.push_back(8'hFF);
        delims.push_back(8'h2C);
        delims.push_back(8'($urandom_range(0, 255)));
        delims.push_back(CH_BSLASH);
        delims.push_back(8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].b, dir_rows[k].e, dir_rows[k].n, dir_rows[k].w);
            dir_cnt++;
        end
        drain_out();

        foreach (delims[k]) begin
            // no idling in the final phase
            if (k == delims.size() - 1) calm = 1'b1;
            write_delim(delims[k]);
            run_random(PHASE_ITEMS);
            drain_out();
        end

        $display("Run covered %0d input items (%0d from the directed table) over %0d delimiter",
                 in_cnt, dir_cnt, phase_cnt);
        $display("settings beside the reset one, with %0d output items checked", out_cnt);
        if (mismatch_cnt == 0 && latin_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/u8l1_pkg.sv
sv/u8l1_front.sv
sv/u8l1_queue.sv
sv/u8l1_back.sv
sv/utf8_to_latin1_escaping_decoder_unit.sv
sim/tb_top.sv
